[design/meter_reading_display_scaler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Meter reading display scaler assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef METER_READING_DISPLAY_SCALER_UNIT_DEFINES_SVH
`define METER_READING_DISPLAY_SCALER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MRDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrds port check failed");

// Next-cycle implication, disabled during reset
`define MRDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrds port check failed");

`endif

[design/mrds_pkg.sv]
// ----------------------------------------------------------------------------
// Meter reading display scaler package
// Operation codes, register indexes, scaling constants and the stage record.
// ----------------------------------------------------------------------------
package mrds_pkg;

  // Operation codes
  localparam logic [2:0] OP_REACTIVE = 3'd1;
  localparam logic [2:0] OP_ACTIVE   = 3'd2;
  localparam logic [2:0] OP_VOLTAGE  = 3'd3;
  localparam logic [2:0] OP_CURRENT  = 3'd4;
  localparam logic [2:0] OP_PFACTOR  = 3'd5;

  // Register indexes
  localparam logic [1:0] CFG_VOLTAGE_RATIO = 2'd0;
  localparam logic [1:0] CFG_CURRENT_RATIO = 2'd1;

  // Scaling constants
  localparam int QUO_W   = 28;          // top bit marks quotient >= 2^27
  localparam int DEN_W   = 26;
  localparam int REM_W   = 64;

  localparam logic [8:0]  K_POWER   = 9'd500;
  localparam logic [8:0]  K_VOLTAGE = 9'd220;
  localparam logic [8:0]  K_ONE     = 9'd1;
  localparam logic [22:0] DEN_POWER = 23'd5365200;   // 53652 * 100
  localparam logic [22:0] DEN_TENK  = 23'd10000;

  // Reciprocals for constant division of the 27-bit quotient and the ratio code
  localparam logic [26:0] RCP_10K  = 27'd109951163;  // ceil(2^40 / 10000)
  localparam logic [20:0] RCP_10   = 21'd1677722;    // ceil(2^24 / 10)
  localparam logic [16:0] RCP_DIG  = 17'd52429;      // ceil(2^19 / 10)

  localparam logic [26:0] LIM_MEGA_SAT = 27'd100000000;
  localparam logic [26:0] LIM_MEGA     = 27'd1000000;
  localparam logic [26:0] LIM_KILO     = 27'd1000;
  localparam logic [15:0] DISP_MEGA_MAX = 16'd9999;
  localparam logic [15:0] DISP_PF_ONE   = 16'd1000;
  localparam logic [15:0] DISP_MAX      = 16'hFFFF;

  // Record handed from cell to cell
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic [2:0]       op;
    logic             neg;
    logic             nz;
    logic             err;
    logic             pf_one;
  } stage_t;

endpackage

[design/mrds_front.sv]
// ----------------------------------------------------------------------------
// Meter reading display scaler front end
// Takes the magnitude and builds the numerator and divisor in three stages.
// ----------------------------------------------------------------------------
module mrds_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [23:0]          raw_reading,
  input  logic [2:0]           operation,
  input  logic [15:0]          voltage_ratio,
  input  logic [15:0]          current_ratio_code,
  output logic                 out_valid,
  output mrds_pkg::stage_t     out_stage
);

  logic [23:0] mag;
  logic        is_pow, is_volt, is_cur;
  logic [31:0] dig_prod;
  logic [3:0]  digit;
  logic [8:0]  k1;
  logic [25:0] den;

  logic        f1_valid, f2_valid, f3_valid;
  logic [32:0] f1_m1;
  logic [15:0] f1_pt, f1_ct, f2_ct;
  logic [48:0] f2_m2;
  logic [64:0] prod3;
  mrds_pkg::stage_t f1_s, f2_s, f3_s;
  mrds_pkg::stage_t f1_next, f3_next;

  // Decode operation and ratio digit
  assign is_pow  = (operation == mrds_pkg::OP_REACTIVE) || (operation == mrds_pkg::OP_ACTIVE);
  assign is_volt = (operation == mrds_pkg::OP_VOLTAGE);
  assign is_cur  = (operation == mrds_pkg::OP_CURRENT);
  assign mag = raw_reading[23] ? 24'(25'h1000000 - {1'b0, raw_reading}) : raw_reading;
  assign dig_prod = 32'(current_ratio_code) * 32'(mrds_pkg::RCP_DIG);
  assign digit = 4'(current_ratio_code - (16'(dig_prod[31:19]) * 16'd10));

  always_comb begin
    if (is_pow) begin
      k1  = mrds_pkg::K_POWER;
      den = 26'(mrds_pkg::DEN_POWER) * 26'(digit);
    end else if (is_volt) begin
      k1  = mrds_pkg::K_VOLTAGE;
      den = 26'(mrds_pkg::DEN_TENK);
    end else begin
      k1  = mrds_pkg::K_ONE;
      den = 26'(mrds_pkg::DEN_TENK) * 26'(digit);
    end
  end

  // Build the first stage record
  always_comb begin
    f1_next        = '0;
    f1_next.den    = den;
    f1_next.op     = operation;
    f1_next.neg    = raw_reading[23];
    f1_next.err    = (is_pow || is_cur) && (digit == 4'd0);
    f1_next.pf_one = !raw_reading[23] && (mag != 24'd0);
  end

  assign prod3 = 65'(f2_m2) * 65'(f2_ct);

  // Load the numerator into the third stage record
  always_comb begin
    f3_next     = f2_s;
    f3_next.rem = prod3[63:0];
    f3_next.nz  = (prod3[63:0] != 64'd0);
  end

  // Advance the three multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_m1 <= 33'(mag) * 33'(k1);
      f1_pt <= (is_pow || is_volt) ? voltage_ratio : 16'd1;
      f1_ct <= (is_pow || is_cur) ? current_ratio_code : 16'd1;
      f1_s  <= f1_next;

      f2_m2 <= 49'(f1_m1) * 49'(f1_pt);
      f2_ct <= f1_ct;
      f2_s  <= f1_s;

      f3_s  <= f3_next;
    end
  end

  assign out_valid = f3_valid;
  assign out_stage = f3_s;

endmodule

[design/mrds_div_cell.sv]
// ----------------------------------------------------------------------------
// Meter reading display scaler divider cell
// One restoring step: settles one quotient bit and passes the record on.
// ----------------------------------------------------------------------------
module mrds_div_cell #(
  parameter int SHIFT_BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  mrds_pkg::stage_t in_stage,
  output logic             out_valid,
  output mrds_pkg::stage_t out_stage
);

  logic [mrds_pkg::REM_W-1:0] dsh;
  logic                       take;
  mrds_pkg::stage_t           stage_next;

  // Compare against the shifted divisor
  assign dsh  = mrds_pkg::REM_W'(in_stage.den) << SHIFT_BIT;
  assign take = (in_stage.rem >= dsh);

  // Subtract and shift in the quotient bit
  always_comb begin
    stage_next     = in_stage;
    stage_next.rem = take ? (in_stage.rem - dsh) : in_stage.rem;
    stage_next.quo = {in_stage.quo[mrds_pkg::QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

[design/meter_reading_display_scaler_unit.sv]
// Pipeline: 3 multiply stages, 28 divider cells and 2 range/saturation
// stages between input transfer and result.
// Throughput: one reading per cycle; the whole pipeline holds while a
// result waits at the output.
// Reset: synchronous rst empties the pipeline and loads voltage_ratio 10
// and current_ratio_code 11.
// ----------------------------------------------------------------------------
// Meter reading display scaler
// Scales a metering register reading into a 16-bit display number.
// ----------------------------------------------------------------------------
module meter_reading_display_scaler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] raw_reading
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] display_value
  output logic [2:0]  m_tuser,   // [0] unit_mega, [1] negative, [2] config_error
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NCELL = mrds_pkg::QUO_W;

  logic        en;
  logic [15:0] voltage_ratio, current_ratio_code;
  logic             cv [0:NCELL];
  mrds_pkg::stage_t cs [0:NCELL];

  logic        p1_valid;
  logic [2:0]  p1_op;
  logic        p1_sat, p1_ge_sat, p1_ge_mega, p1_ge_kilo;
  logic        p1_sgn, p1_err, p1_pf_one;
  logic [13:0] p1_d10k;
  logic [16:0] p1_d10;
  logic [33:0] p1_x100;
  logic [30:0] p1_x10;
  logic [26:0] q;
  logic [53:0] prod_10k;
  logic [47:0] prod_10;
  logic [15:0] disp_next;
  logic        mega_next, sgn_next, err_next;

  // Hold everything while a result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_ratio      <= 16'd10;
      current_ratio_code <= 16'd11;
    end else if (cfg_we) begin
      if (cfg_index == mrds_pkg::CFG_VOLTAGE_RATIO) begin
        voltage_ratio <= cfg_data;
      end else if (cfg_index == mrds_pkg::CFG_CURRENT_RATIO) begin
        current_ratio_code <= cfg_data;
      end
    end
  end

  mrds_front u_front (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .in_valid           (s_tvalid),
    .raw_reading        (s_tdata),
    .operation          (s_tuser),
    .voltage_ratio      (voltage_ratio),
    .current_ratio_code (current_ratio_code),
    .out_valid          (cv[0]),
    .out_stage          (cs[0])
  );

  // Divider cell chain, most significant quotient bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mrds_div_cell #(.SHIFT_BIT(NCELL - 1 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .in_stage  (cs[i]),
      .out_valid (cv[i+1]),
      .out_stage (cs[i+1])
    );
  end

  assign q        = cs[NCELL].quo[26:0];
  assign prod_10k = 54'(q) * 54'(mrds_pkg::RCP_10K);
  assign prod_10  = 48'(q) * 48'(mrds_pkg::RCP_10);

  // Range compares and constant scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op      <= cs[NCELL].op;
      p1_sat     <= cs[NCELL].quo[NCELL-1];
      p1_ge_sat  <= cs[NCELL].quo[NCELL-1] || (q >= mrds_pkg::LIM_MEGA_SAT);
      p1_ge_mega <= (q >= mrds_pkg::LIM_MEGA);
      p1_ge_kilo <= (q >= mrds_pkg::LIM_KILO);
      p1_sgn     <= cs[NCELL].neg && cs[NCELL].nz;
      p1_err     <= cs[NCELL].err;
      p1_pf_one  <= cs[NCELL].pf_one;
      p1_d10k    <= prod_10k[53:40];
      p1_d10     <= prod_10[40:24];
      p1_x100    <= 34'(q) * 34'd100;
      p1_x10     <= 31'(q) * 31'd10;
    end
  end

  // Select the display value per operation
  always_comb begin
    disp_next = 16'd0;
    mega_next = 1'b0;
    sgn_next  = 1'b0;
    err_next  = 1'b0;
    case (p1_op)
      mrds_pkg::OP_REACTIVE, mrds_pkg::OP_ACTIVE: begin
        if (p1_err) begin
          err_next = 1'b1;
        end else begin
          sgn_next = p1_sgn;
          if (p1_ge_sat) begin
            disp_next = mrds_pkg::DISP_MEGA_MAX;
            mega_next = 1'b1;
          end else if (p1_ge_mega) begin
            disp_next = 16'(p1_d10k);
            mega_next = 1'b1;
          end else if (p1_ge_kilo) begin
            disp_next = p1_d10[16] ? mrds_pkg::DISP_MAX : p1_d10[15:0];
          end else begin
            disp_next = (p1_x100[33:16] != 18'd0) ? mrds_pkg::DISP_MAX : p1_x100[15:0];
          end
        end
      end
      mrds_pkg::OP_VOLTAGE: begin
        disp_next = (p1_sat || p1_x100[33:16] != 18'd0) ? mrds_pkg::DISP_MAX : p1_x100[15:0];
      end
      mrds_pkg::OP_CURRENT: begin
        if (p1_err) begin
          err_next = 1'b1;
        end else begin
          disp_next = (p1_sat || p1_x10[30:16] != 15'd0) ? mrds_pkg::DISP_MAX : p1_x10[15:0];
        end
      end
      mrds_pkg::OP_PFACTOR: begin
        disp_next = p1_pf_one ? mrds_pkg::DISP_PF_ONE : 16'd0;
      end
      default: begin
        disp_next = 16'd0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= disp_next;
      m_tuser <= {err_next, sgn_next, mega_next};
    end
  end

endmodule

[design/mrds_checker.sv]
// ----------------------------------------------------------------------------
// Meter reading display scaler port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "meter_reading_display_scaler_unit_defines.svh"

module mrds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // Stalled result holds
  `MRDS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Input side opens exactly when the output slot can move
  `MRDS_ASSERT_NOW(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready))

  // Mega readings never exceed four digits
  `MRDS_ASSERT_NOW(a_mega, m_tvalid && m_tuser[0], m_tdata <= 16'd9999)

  // Ratio fault gives a blank result
  `MRDS_ASSERT_NOW(a_err, m_tvalid && m_tuser[2], m_tdata == 16'd0 && !m_tuser[0] && !m_tuser[1])

endmodule

bind meter_reading_display_scaler_unit mrds_checker u_mrds_checker (.*);
